/* rtl/sfd_pkg.sv */
// Shared constants, tables and types of the SENT frame decoder.
package sfd_pkg;

    localparam int PULSE_W          = 16;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 1;
    localparam int UNIT_W           = 11;
    localparam int DVD_W            = PULSE_W + 1;
    localparam int CAPTURE_BITS_DEF = 16;
    localparam int NIB_W            = 4;
    localparam int DATA_W           = 24;
    localparam int HIST_W           = 18;
    localparam int CBITS_W          = 24;
    localparam int CRC6_W           = 6;
    localparam int EV_W             = 3;
    localparam int ID_W             = 8;
    localparam int SDAT_W           = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MAX = 1'b1;

    localparam logic [CFG_W-1:0]   SYNC_MIN_RST = 16'd6200;
    localparam logic [CFG_W-1:0]   SYNC_MAX_RST = 16'd7400;
    localparam logic [UNIT_W-1:0]  SYNC_DIV     = 11'd56;
    localparam logic [UNIT_W-1:0]  TICK_RST     = 11'd126;
    localparam logic [UNIT_W-1:0]  UNIT_MAX     = 11'd2047;
    localparam logic [DVD_W-1:0]   TICK_MIN     = 17'd12;
    localparam logic [DVD_W-1:0]   TICK_MAX     = 17'd27;
    localparam logic [HIST_W-1:0]  SLOW_MASK    = 18'h3F821;
    localparam logic [HIST_W-1:0]  SLOW_MATCH   = 18'h3F000;
    localparam logic [CRC6_W-1:0]  CRC6_SEED    = 6'd59;
    localparam logic [NIB_W-1:0]   CRC4_SEED    = 4'h3;

    localparam logic [EV_W-1:0] EV_SYNC   = 3'd0;
    localparam logic [EV_W-1:0] EV_REJECT = 3'd1;
    localparam logic [EV_W-1:0] EV_NIBBLE = 3'd2;
    localparam logic [EV_W-1:0] EV_CRC_OK = 3'd3;
    localparam logic [EV_W-1:0] EV_CRC_BAD = 3'd4;
    localparam logic [EV_W-1:0] EV_STRAY  = 3'd5;

    localparam logic [NIB_W-1:0] CRC4_TAB [16] = '{
        4'd0, 4'd13, 4'd7, 4'd10, 4'd14, 4'd3, 4'd9, 4'd4,
        4'd1, 4'd12, 4'd6, 4'd11, 4'd15, 4'd2, 4'd8, 4'd5};

    localparam logic [CRC6_W-1:0] CRC6_TAB [64] = '{
        6'd0,  6'd25, 6'd50, 6'd43, 6'd61, 6'd36, 6'd15, 6'd22,
        6'd35, 6'd58, 6'd17, 6'd8,  6'd30, 6'd7,  6'd44, 6'd53,
        6'd31, 6'd6,  6'd45, 6'd52, 6'd34, 6'd59, 6'd16, 6'd9,
        6'd60, 6'd37, 6'd14, 6'd23, 6'd1,  6'd24, 6'd51, 6'd42,
        6'd62, 6'd39, 6'd12, 6'd21, 6'd3,  6'd26, 6'd49, 6'd40,
        6'd29, 6'd4,  6'd47, 6'd54, 6'd32, 6'd57, 6'd18, 6'd11,
        6'd33, 6'd56, 6'd19, 6'd10, 6'd28, 6'd5,  6'd46, 6'd55,
        6'd2,  6'd27, 6'd48, 6'd41, 6'd63, 6'd38, 6'd13, 6'd20};

    // Frame position; the data phases are consecutive so a left shift advances them.
    typedef enum logic [8:0] {
        PH_IDLE = 9'b000000001,
        PH_SER  = 9'b000000010,
        PH_D1   = 9'b000000100,
        PH_D2   = 9'b000001000,
        PH_D3   = 9'b000010000,
        PH_D4   = 9'b000100000,
        PH_D5   = 9'b001000000,
        PH_D6   = 9'b010000000,
        PH_CS   = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [NIB_W-1:0]  nibble_value;
        logic [DATA_W-1:0] fast_data;
        logic              slow_valid;
        logic              slow_format;
        logic [ID_W-1:0]   slow_id;
        logic [SDAT_W-1:0] slow_data;
        logic [UNIT_W-1:0] clock_unit;
    } t_result;

endpackage

/* rtl/sfd_if.sv */
// Valid/ready channel interfaces for pulse items in and decoded event items out.
interface sfd_in_if;
    logic                         valid;
    logic                         ready;
    logic [sfd_pkg::PULSE_W-1:0]  pulse_count;

    modport source (output valid, output pulse_count, input ready);
    modport sink   (input valid, input pulse_count, output ready);
endinterface

interface sfd_out_if;
    logic                         valid;
    logic                         ready;
    logic [sfd_pkg::EV_W-1:0]     event_res;
    logic [sfd_pkg::NIB_W-1:0]    nibble_value;
    logic [sfd_pkg::DATA_W-1:0]   fast_data;
    logic                         slow_valid;
    logic                         slow_format;
    logic [sfd_pkg::ID_W-1:0]     slow_id;
    logic [sfd_pkg::SDAT_W-1:0]   slow_data;
    logic [sfd_pkg::UNIT_W-1:0]   clock_unit;

    modport source (output valid, output event_res, output nibble_value, output fast_data,
                    output slow_valid, output slow_format, output slow_id, output slow_data,
                    output clock_unit, input ready);
    modport sink   (input valid, input event_res, input nibble_value, input fast_data,
                    input slow_valid, input slow_format, input slow_id, input slow_data,
                    input clock_unit, output ready);
endinterface

/* rtl/sfd_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module sfd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sfd_pkg::DVD_W-1:0]   i_dividend,
    input  logic [sfd_pkg::UNIT_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [sfd_pkg::DVD_W-1:0]   o_quot
);
    import sfd_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [UNIT_W-1:0] r_div;
    logic [UNIT_W-1:0] r_rem;
    logic [DVD_W-1:0]  r_q;
    logic [UNIT_W:0]   w_trial;
    logic [UNIT_W:0]   w_diff;
    logic              w_ge;

    // The remainder stays below the divisor, so the trial value fits one extra bit.
    assign w_trial = {r_rem, r_q[DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[UNIT_W-1:0] : w_trial[UNIT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* rtl/sfd_crc6.sv */
// Serial CRC6 over the 24 serial bits, one six-bit digit per cycle.
module sfd_crc6 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sfd_pkg::CBITS_W-1:0]   i_bits,
    output logic                          o_done,
    output logic [sfd_pkg::CRC6_W-1:0]    o_crc
);
    import sfd_pkg::*;

    localparam int STEPS = CBITS_W / CRC6_W;
    localparam int CNT_W = $clog2(STEPS);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [CBITS_W-1:0] r_sh;
    logic [CRC6_W-1:0]  r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh <= i_bits;
            r_c  <= CRC6_SEED;
        end else if (r_busy) begin
            r_c  <= CRC6_TAB[r_c ^ r_sh[CBITS_W-1 -: CRC6_W]];
            r_sh <= r_sh << CRC6_W;
        end
    end

    assign o_done = r_done;
    assign o_crc  = r_c;

endmodule

/* rtl/sent_frame_decoder_with_slow_channel.sv */
// Top level of the single-channel SENT frame decoder with enhanced serial messages.
//
// The block takes one captured falling-edge period per input item and returns exactly one
// event item for it. A period strictly between the two sync limits is a sync pulse: it sets
// the clock unit to period/56 (at least 1) and starts a frame. Any other period is rounded to
// whole ticks; 12 to 27 ticks give a nibble, anything else rejects the frame. The status
// nibble feeds the enhanced serial message, which is reported when its bit pattern and CRC6 pass, and the
// six data nibbles are checked against the checksum nibble with CRC4. Each item passes in
// turn through the bit-serial divider that rounds the period (or forms period/56 on a sync),
// the hand-over of the quotient to the digit-serial CRC6 unit, that unit, the hand-over of
// its check value and a write-back, which waits while the output register holds a result
// that is not yet taken. The input reopens in the cycle after the write-back, so only one
// item is in work at a time. A new item is accepted as soon as the previous one is written
// back, even while its result still waits in the output register.
// Configuration writes are taken at any time and must only be issued while the block is idle.
module sent_frame_decoder_with_slow_channel #(
    parameter int CAPTURE_BITS = sfd_pkg::CAPTURE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfd_pkg::CFG_W-1:0]      i_cfg_data,
    sfd_in_if.sink                         i_in,
    sfd_out_if.source                      o_out
);
    import sfd_pkg::*;

    // Capture counts beyond the timer width are dropped before anything else sees them.
    localparam logic [PULSE_W-1:0] P_MASK = (CAPTURE_BITS >= PULSE_W) ? {PULSE_W{1'b1}}
                                          : PULSE_W'((64'd1 << CAPTURE_BITS) - 64'd1);

    typedef enum logic [3:0] {
        SQ_IDLE = 4'b0001,
        SQ_DIV  = 4'b0010,
        SQ_CRC  = 4'b0100,
        SQ_WB   = 4'b1000
    } t_seq;

    // Sequencer and configuration.
    t_seq              r_seq, n_seq;
    logic [CFG_W-1:0]  r_sync_min;
    logic [CFG_W-1:0]  r_sync_max;

    // Frame state that persists across items.
    t_phase             r_phase, n_phase;
    logic [UNIT_W-1:0]  r_tick, n_tick;
    logic [NIB_W-1:0]   r_crc4, n_crc4;
    logic [DATA_W-1:0]  r_data, n_data;
    logic [HIST_W-1:0]  r_h2, n_h2;
    logic [HIST_W-1:0]  r_h3, n_h3;
    logic [CBITS_W-1:0] r_cbits, n_cbits;

    // Per-item working registers.
    logic               r_sync;
    logic               r_nib_ok;
    logic [NIB_W-1:0]   r_nib;
    logic [UNIT_W-1:0]  r_unit;

    // Output register.
    logic               r_out_valid;
    t_result            r_res, n_res;

    logic [PULSE_W-1:0] w_p;
    logic               w_is_sync;
    logic               w_accept;
    logic [DVD_W-1:0]   w_dividend;
    logic [UNIT_W-1:0]  w_divisor;
    logic               w_div_done;
    logic [DVD_W-1:0]   w_quot;
    logic [NIB_W-1:0]   w_nib;
    logic               w_crc_start;
    logic [CBITS_W-1:0] w_crc_bits;
    logic               w_crc_done;
    logic [CRC6_W-1:0]  w_crc6;
    logic               w_wb_fire;
    logic [HIST_W-1:0]  w_h2c;
    logic [HIST_W-1:0]  w_h3c;
    logic               w_slow_ok;
    logic [NIB_W-1:0]   w_seed;

    assign i_in.ready = (r_seq == SQ_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_p        = i_in.pulse_count & P_MASK;
    assign w_is_sync  = (w_p > r_sync_min) && (w_p < r_sync_max);

    // A sync divides by 56; otherwise half a unit is added so the quotient rounds to nearest.
    assign w_dividend = w_is_sync ? DVD_W'(w_p)
                                  : DVD_W'(w_p) + DVD_W'(r_tick >> 1);
    assign w_divisor  = w_is_sync ? SYNC_DIV : r_tick;

    sfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // The nibble is the tick count minus twelve; only its low bits matter once range-checked.
    assign w_nib       = w_quot[NIB_W-1:0] - TICK_MIN[NIB_W-1:0];
    assign w_crc_start = (r_seq == SQ_DIV) && w_div_done;
    assign w_crc_bits  = {r_cbits[CBITS_W-3:0], w_nib[2], w_nib[3]};

    sfd_crc6 u_crc6 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_crc_start),
        .i_bits  (w_crc_bits),
        .o_done  (w_crc_done),
        .o_crc   (w_crc6)
    );

    assign w_wb_fire = (r_seq == SQ_WB) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SQ_IDLE: begin
                if (w_accept) n_seq = SQ_DIV;
            end
            SQ_DIV: begin
                if (w_div_done) n_seq = SQ_CRC;
            end
            SQ_CRC: begin
                if (w_crc_done) n_seq = SQ_WB;
            end
            SQ_WB: begin
                if (w_wb_fire) n_seq = SQ_IDLE;
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    // The serial message check looks at the histories as they stand after this nibble.
    assign w_h2c     = {r_h2[HIST_W-2:0], r_nib[2]};
    assign w_h3c     = {r_h3[HIST_W-2:0], r_nib[3]};
    assign w_slow_ok = ((w_h3c & SLOW_MASK) == SLOW_MATCH) &&
                       (w_crc6 == w_h2c[HIST_W-1 -: CRC6_W]);
    assign w_seed    = (r_phase == PH_D1) ? CRC4_SEED : r_crc4;

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_crc4  = r_crc4;
        n_data  = r_data;
        n_h2    = r_h2;
        n_h3    = r_h3;
        n_cbits = r_cbits;
        n_res   = '0;
        if (r_sync) begin
            n_tick          = r_unit;
            n_phase         = PH_SER;
            n_res.event_res = EV_SYNC;
        end else if (!r_nib_ok) begin
            n_phase         = PH_IDLE;
            n_res.event_res = EV_REJECT;
        end else begin
            n_res.nibble_value = r_nib;
            case (r_phase)
                PH_SER: begin
                    n_h2    = w_h2c;
                    n_h3    = w_h3c;
                    n_cbits = {r_cbits[CBITS_W-3:0], r_nib[2], r_nib[3]};
                    if (w_slow_ok) begin
                        n_res.slow_valid  = 1'b1;
                        n_res.slow_format = w_h3c[10];
                        if (!w_h3c[10]) begin
                            // Eight-bit id, twelve-bit data.
                            n_res.slow_id   = {w_h3c[9:6], w_h3c[4:1]};
                            n_res.slow_data = {4'd0, w_h2c[11:0]};
                        end else begin
                            // Four-bit id, sixteen-bit data.
                            n_res.slow_id   = {4'd0, w_h3c[9:6]};
                            n_res.slow_data = {w_h3c[4:1], w_h2c[11:0]};
                        end
                    end
                    n_phase         = PH_D1;
                    n_res.event_res = EV_NIBBLE;
                end
                PH_D1, PH_D2, PH_D3, PH_D4, PH_D5, PH_D6: begin
                    n_crc4          = CRC4_TAB[w_seed ^ r_nib];
                    n_data          = {r_data[DATA_W-NIB_W-1:0], r_nib};
                    n_phase         = t_phase'(r_phase << 1);
                    n_res.event_res = EV_NIBBLE;
                end
                PH_CS: begin
                    n_res.event_res = (r_crc4 == r_nib) ? EV_CRC_OK : EV_CRC_BAD;
                    n_res.fast_data = r_data;
                    n_phase         = PH_IDLE;
                end
                default: begin
                    n_phase         = PH_IDLE;
                    n_res.event_res = EV_STRAY;
                end
            endcase
        end
        n_res.clock_unit = n_tick;
    end

    // Control state, configuration and the frame state that has a defined reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_out_valid <= 1'b0;
            r_sync_min  <= SYNC_MIN_RST;
            r_sync_max  <= SYNC_MAX_RST;
            r_phase     <= PH_IDLE;
            r_tick      <= TICK_RST;
            r_crc4      <= '0;
            r_h2        <= '0;
            r_h3        <= '0;
            r_cbits     <= '0;
        end else begin
            r_seq       <= n_seq;
            r_out_valid <= w_wb_fire || (r_out_valid && !o_out.ready);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC_MIN: r_sync_min <= i_cfg_data;
                    CFG_SYNC_MAX: r_sync_max <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_wb_fire) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_crc4  <= n_crc4;
                r_h2    <= n_h2;
                r_h3    <= n_h3;
                r_cbits <= n_cbits;
            end
        end
    end

    // Payload registers; the data nibbles have no defined value until written.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sync <= w_is_sync;
        end
        if (w_crc_start) begin
            r_nib_ok <= (w_quot >= TICK_MIN) && (w_quot <= TICK_MAX);
            r_nib    <= w_nib;
            if (w_quot == '0) begin
                r_unit <= UNIT_W'(1);
            end else if (w_quot > DVD_W'(UNIT_MAX)) begin
                r_unit <= UNIT_MAX;
            end else begin
                r_unit <= w_quot[UNIT_W-1:0];
            end
        end
        if (w_wb_fire) begin
            r_data <= n_data;
            r_res  <= n_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_res.event_res;
    assign o_out.nibble_value = r_res.nibble_value;
    assign o_out.fast_data    = r_res.fast_data;
    assign o_out.slow_valid   = r_res.slow_valid;
    assign o_out.slow_format  = r_res.slow_format;
    assign o_out.slow_id      = r_res.slow_id;
    assign o_out.slow_data    = r_res.slow_data;
    assign o_out.clock_unit   = r_res.clock_unit;

endmodule

/* rtl/sfd_checker.sv */
// Port-level checks of the SENT frame decoder, bound to its top level.
module sfd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [sfd_pkg::EV_W-1:0]       i_event_res,
    input logic [sfd_pkg::DATA_W-1:0]     i_fast_data,
    input logic                           i_slow_valid,
    input logic                           i_slow_format,
    input logic [sfd_pkg::ID_W-1:0]       i_slow_id,
    input logic [sfd_pkg::SDAT_W-1:0]     i_slow_data,
    input logic [sfd_pkg::UNIT_W-1:0]     i_clock_unit
);
    import sfd_pkg::*;

    // A waiting result keeps its event code until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_res))
        else $error("output item changed while stalled");

    // Items are worked on one at a time, so the input closes right after an acceptance.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while an item is in work");

    // Frame data is shown on checksum events only.
    a_fast_only_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res != EV_CRC_OK && i_event_res != EV_CRC_BAD
        |-> i_fast_data == '0)
        else $error("fast data shown outside a checksum event");

    // Serial fields are zero unless a message passed its check.
    a_slow_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_slow_valid
        |-> !i_slow_format && i_slow_id == '0 && i_slow_data == '0)
        else $error("serial fields set without a valid message");

    // The clock unit never drops to zero.
    a_unit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_clock_unit != '0)
        else $error("clock unit reported as zero");

endmodule

bind sent_frame_decoder_with_slow_channel sfd_checker u_sfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_event_res   (o_out.event_res),
    .i_fast_data   (o_out.fast_data),
    .i_slow_valid  (o_out.slow_valid),
    .i_slow_format (o_out.slow_format),
    .i_slow_id     (o_out.slow_id),
    .i_slow_data   (o_out.slow_data),
    .i_clock_unit  (o_out.clock_unit)
);
